/* src/ptc_pkg.sv */
// Shared types, constants and helper functions for the pressure/temperature compensation block.
package ptc_pkg;

    localparam logic [31:0] FINE_OFFSET = 32'd64000;
    localparam logic [31:0] RAW_SPAN    = 32'd1048576;
    localparam logic [31:0] PRESS_SCALE = 32'd3125;
    localparam logic [31:0] DIV_BIAS    = 32'd32768;
    localparam logic [31:0] ROUND_HALF  = 32'd128;
    localparam int          DIV_STAGES  = 32;

    typedef enum logic [1:0] {
        REG_TEMP_TRIM  = 2'd0,
        REG_PRESS_LOW  = 2'd1,
        REG_PRESS_HIGH = 2'd2,
        REG_PRESS_LAST = 2'd3
    } t_reg_idx;

    // Sideband carried alongside the divider
    typedef struct packed {
        logic [31:0] temp;
        logic        dbl;
        logic        inv;
    } t_div_side;

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] press;
        logic        inv;
    } t_result;

    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
        asr = $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] v);
        sext16 = {{16{v[15]}}, v};
    endfunction

endpackage

/* src/ptc_div.sv */
// Fully pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
module ptc_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [31:0]           i_dividend,
    input  logic [31:0]           i_divisor,
    input  ptc_pkg::t_div_side    i_side,
    output logic                  o_valid,
    output logic [31:0]           o_quotient,
    output ptc_pkg::t_div_side    o_side
);

    localparam int N = ptc_pkg::DIV_STAGES;

    logic [31:0]        r_rem  [1:N];
    logic [31:0]        r_nq   [1:N];
    logic [31:0]        r_dvs  [1:N];
    ptc_pkg::t_div_side r_side [1:N];
    logic [N:1]         r_vld;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    // Returns the new partial remainder above the shifted quotient word.
    function automatic logic [63:0] div_step(input logic [31:0] rem, input logic [31:0] nq,
                                             input logic [31:0] dvs);
        logic [32:0] trial;
        logic [32:0] diff;
        logic        take;
        trial    = {rem, nq[31]};
        diff     = trial - {1'b0, dvs};
        take     = (trial >= {1'b0, dvs});
        div_step = {(take ? diff[31:0] : trial[31:0]), nq[30:0], take};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N-1:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            {r_rem[1], r_nq[1]} <= div_step(32'd0, i_dividend, i_divisor);
            r_dvs[1]            <= i_divisor;
            r_side[1]           <= i_side;
            for (int k = 2; k <= N; k++) begin
                {r_rem[k], r_nq[k]} <= div_step(r_rem[k-1], r_nq[k-1], r_dvs[k-1]);
                r_dvs[k]            <= r_dvs[k-1];
                r_side[k]           <= r_side[k-1];
            end
        end
    end

    assign o_valid    = r_vld[N];
    assign o_quotient = r_nq[N];
    assign o_side     = r_side[N];

endmodule

/* src/pressure_temperature_compensation_top.sv */
// Top level of the pressure/temperature compensation pipeline with its APB trim registers.
//
// Takes one raw temperature/pressure pair per transfer and returns the temperature in
// hundredths of a degree and the pressure in pascals, using the standard 32-bit integer
// compensation with wrap-around arithmetic. The datapath is a fixed pipeline that accepts
// a new pair every cycle while o_ready is high. It has 10 stages of multiplies and adds,
// 32 stages of the bit-per-stage divider, 2 stages of pressure correction and the output
// buffer. A two-entry output buffer lets the pipeline keep flowing while a result waits;
// o_ready drops only when both entries are full, which freezes every stage in place.
// Trim registers sit at byte addresses 0, 8, 16 and 24 and must be written only while
// no transfer is in flight. A zero pressure divisor gives a pressure of 0 with
// o_pressure_invalid set; the temperature is still reported.
module pressure_temperature_compensation_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [19:0] i_raw_temperature,
    input  logic [19:0] i_raw_pressure,
    // output channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_temperature_centi,
    output logic [31:0] o_pressure_pa,
    output logic        o_pressure_invalid,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // ---------------- trim registers ----------------
    logic [47:0] r_temp_trim;
    logic [63:0] r_press_low;
    logic [63:0] r_press_high;
    logic [15:0] r_press_last;
    ptc_pkg::t_reg_idx n_idx;

    assign pready = 1'b1;
    assign n_idx  = ptc_pkg::t_reg_idx'(paddr[4:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_trim  <= '0;
            r_press_low  <= '0;
            r_press_high <= '0;
            r_press_last <= '0;
        end else if (psel && penable && pwrite) begin
            case (n_idx)
                ptc_pkg::REG_TEMP_TRIM:  r_temp_trim  <= pwdata[47:0];
                ptc_pkg::REG_PRESS_LOW:  r_press_low  <= pwdata;
                ptc_pkg::REG_PRESS_HIGH: r_press_high <= pwdata;
                ptc_pkg::REG_PRESS_LAST: r_press_last <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (n_idx)
            ptc_pkg::REG_TEMP_TRIM:  prdata = {16'b0, r_temp_trim};
            ptc_pkg::REG_PRESS_LOW:  prdata = r_press_low;
            ptc_pkg::REG_PRESS_HIGH: prdata = r_press_high;
            ptc_pkg::REG_PRESS_LAST: prdata = {48'b0, r_press_last};
            default:                 prdata = '0;
        endcase
    end

    // Coefficients widened to 32 bits: t1 and p1 zero-extended, the rest sign-extended
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'b0, r_temp_trim[15:0]};
    assign t2 = ptc_pkg::sext16(r_temp_trim[31:16]);
    assign t3 = ptc_pkg::sext16(r_temp_trim[47:32]);
    assign p1 = {16'b0, r_press_low[15:0]};
    assign p2 = ptc_pkg::sext16(r_press_low[31:16]);
    assign p3 = ptc_pkg::sext16(r_press_low[47:32]);
    assign p4 = ptc_pkg::sext16(r_press_low[63:48]);
    assign p5 = ptc_pkg::sext16(r_press_high[15:0]);
    assign p6 = ptc_pkg::sext16(r_press_high[31:16]);
    assign p7 = ptc_pkg::sext16(r_press_high[47:32]);
    assign p8 = ptc_pkg::sext16(r_press_high[63:48]);
    assign p9 = ptc_pkg::sext16(r_press_last);

    // ---------------- pipeline control ----------------
    // Every stage advances together; hold all of them when the output buffer is full.
    logic [1:0] r_cnt;
    logic       en;
    logic       div_vld;
    assign en      = (r_cnt != 2'd2);
    assign o_ready = en;

    // The divider keeps its own valid bits between stage 10 and stage 12.
    logic [10:1] r_vld;
    logic        r12_vld, r13_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r12_vld <= 1'b0;
            r13_vld <= 1'b0;
        end else if (en) begin
            r_vld[1]    <= i_valid;
            r_vld[10:2] <= r_vld[9:1];
            r12_vld     <= div_vld;
            r13_vld     <= r12_vld;
        end
    end

    // ---------------- temperature path ----------------
    logic [31:0] adc_t, adc_p;
    assign adc_t = {12'b0, i_raw_temperature};
    assign adc_p = {12'b0, i_raw_pressure};

    logic [31:0] r1_m1, r1_dd, r1_adcp;
    logic [31:0] r2_at, r2_m2, r2_adcp;
    logic [31:0] r3_fine, r3_adcp;
    logic [31:0] r4_temp, r4_pa, r4_adcp;
    logic [31:0] r5_sq, r5_m5, r5_m2, r5_temp, r5_adcp;
    logic [31:0] r6_b1, r6_m3, r6_m5, r6_m2, r6_temp, r6_adcp;
    logic [31:0] r7_b, r7_a2, r7_temp, r7_adcp;
    logic [31:0] r8_m1, r8_b, r8_temp, r8_adcp;
    logic [31:0] r9_div, r9_pn, r9_temp;
    logic [31:0] r10_pm, r10_div, r10_temp;

    logic [31:0] n1_x, n1_d, n4_q, n5_q, n6_s11, n6_s13;
    assign n1_x   = (adc_t >> 3) - (t1 << 1);
    assign n1_d   = (adc_t >> 4) - t1;
    assign n5_q   = ptc_pkg::asr(r4_pa, 2);
    assign n6_s11 = ptc_pkg::asr(r5_sq, 11);
    assign n6_s13 = ptc_pkg::asr(r5_sq, 13);
    assign n4_q   = (r3_fine << 2) + r3_fine + ptc_pkg::ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1: first two products
            r1_m1   <= n1_x * t2;
            r1_dd   <= n1_d * n1_d;
            r1_adcp <= adc_p;
            // stage 2
            r2_at   <= ptc_pkg::asr(r1_m1, 11);
            r2_m2   <= ptc_pkg::asr(r1_dd, 12) * t3;
            r2_adcp <= r1_adcp;
            // stage 3: fine temperature
            r3_fine <= r2_at + ptc_pkg::asr(r2_m2, 14);
            r3_adcp <= r2_adcp;
            // stage 4: centidegrees and the pressure offset term
            r4_temp <= ptc_pkg::asr(n4_q, 8);
            r4_pa   <= ptc_pkg::asr(r3_fine, 1) - ptc_pkg::FINE_OFFSET;
            r4_adcp <= r3_adcp;
            // stage 5
            r5_sq   <= n5_q * n5_q;
            r5_m5   <= r4_pa * p5;
            r5_m2   <= p2 * r4_pa;
            r5_temp <= r4_temp;
            r5_adcp <= r4_adcp;
            // stage 6
            r6_b1   <= n6_s11 * p6;
            r6_m3   <= p3 * n6_s13;
            r6_m5   <= r5_m5;
            r6_m2   <= r5_m2;
            r6_temp <= r5_temp;
            r6_adcp <= r5_adcp;
            // stage 7: combine into the offset and divisor terms
            r7_b    <= ptc_pkg::asr(r6_b1 + (r6_m5 << 1), 2) + (p4 << 16);
            r7_a2   <= ptc_pkg::asr(ptc_pkg::asr(r6_m3, 3) + ptc_pkg::asr(r6_m2, 1), 18);
            r7_temp <= r6_temp;
            r7_adcp <= r6_adcp;
            // stage 8
            r8_m1   <= (ptc_pkg::DIV_BIAS + r7_a2) * p1;
            r8_b    <= r7_b;
            r8_temp <= r7_temp;
            r8_adcp <= r7_adcp;
            // stage 9: divisor and numerator
            r9_div  <= ptc_pkg::asr(r8_m1, 15);
            r9_pn   <= (ptc_pkg::RAW_SPAN - r8_adcp) - ptc_pkg::asr(r8_b, 12);
            r9_temp <= r8_temp;
            // stage 10
            r10_pm   <= r9_pn * ptc_pkg::PRESS_SCALE;
            r10_div  <= r9_div;
            r10_temp <= r9_temp;
        end
    end

    // ---------------- division ----------------
    // Below half range divide twice the value, else divide and double afterwards.
    logic [31:0]        div_dend;
    ptc_pkg::t_div_side div_in, div_out;
    logic [31:0]        div_q;

    assign div_dend    = r10_pm[31] ? r10_pm : (r10_pm << 1);
    assign div_in.temp = r10_temp;
    assign div_in.dbl  = r10_pm[31];
    assign div_in.inv  = (r10_div == '0);

    ptc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_vld[10]),
        .i_dividend (div_dend),
        .i_divisor  (r10_div),
        .i_side     (div_in),
        .o_valid    (div_vld),
        .o_quotient (div_q),
        .o_side     (div_out)
    );

    // ---------------- final correction ----------------
    logic [31:0] n12_p, n12_s;
    logic [31:0] r12_p, r12_sqp, r12_mb, r12_temp;
    logic        r12_inv;
    logic [31:0] r13_p, r13_ma, r13_mb, r13_temp;
    logic        r13_inv;

    assign n12_p = div_out.inv ? '0 : (div_out.dbl ? (div_q << 1) : div_q);
    assign n12_s = n12_p >> 3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r12_p    <= n12_p;
            r12_sqp  <= n12_s * n12_s;
            r12_mb   <= (n12_p >> 2) * p8;
            r12_temp <= div_out.temp;
            r12_inv  <= div_out.inv;
            r13_ma   <= p9 * (r12_sqp >> 13);
            r13_p    <= r12_p;
            r13_mb   <= r12_mb;
            r13_temp <= r12_temp;
            r13_inv  <= r12_inv;
        end
    end

    ptc_pkg::t_result n_res;
    assign n_res.temp  = r13_temp;
    assign n_res.inv   = r13_inv;
    assign n_res.press = r13_inv ? '0 :
        r13_p + ptc_pkg::asr(ptc_pkg::asr(r13_ma, 12) + ptc_pkg::asr(r13_mb, 13) + p7, 4);

    // ---------------- two-entry output buffer ----------------
    ptc_pkg::t_result r_fq [0:1];
    logic             r_wp, r_rp;
    logic             push, pop;

    assign push = en && r13_vld;
    assign pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_fq[r_wp] <= n_res;
    end

    assign o_valid             = (r_cnt != 2'd0);
    assign o_temperature_centi = r_fq[r_rp].temp;
    assign o_pressure_pa       = r_fq[r_rp].press;
    assign o_pressure_invalid  = r_fq[r_rp].inv;

    // ---------------- assertions ----------------
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("output buffer count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !push) else $error("push into full output buffer");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> o_valid) else $error("transfer into buffer not offered");

    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pressure_invalid |-> o_pressure_pa == '0)
        else $error("invalid pressure not forced to zero");

endmodule

/* test/pressure_temperature_compensation_top_test.sv */
// Self-checking testbench for the pressure/temperature compensation block.
module pressure_temperature_compensation_top_test;

    typedef struct {
        logic [31:0] temp;
        logic [31:0] press;
        logic        inv;
    } t_reading;

    // Scoreboard: holds expected readings and compares each delivered one.
    class reading_board;
        t_reading    pending[$];
        int unsigned errors;

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void note(t_reading r);
            pending.push_back(r);
        endfunction

        task check(logic [31:0] temp, logic [31:0] press, logic inv);
            t_reading e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result temp=%h press=%h", temp, press));
                return;
            end
            e = pending.pop_front();
            if (temp !== e.temp)
                report($sformatf("temperature got %h want %h", temp, e.temp));
            if (press !== e.press)
                report($sformatf("pressure got %h want %h", press, e.press));
            if (inv !== e.inv)
                report($sformatf("invalid flag got %b want %b", inv, e.inv));
        endtask
    endclass

    logic        i_clk, i_rst_n;
    logic        i_valid, o_ready, o_valid, i_ready;
    logic [19:0] i_raw_temperature, i_raw_pressure;
    logic [31:0] o_temperature_centi, o_pressure_pa;
    logic        o_pressure_invalid;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [63:0] pwdata, prdata;

    pressure_temperature_compensation_top dut (.*);

    reading_board board = new();

    // Local copy of the trim registers
    logic [47:0] trim_t;
    logic [63:0] trim_pl, trim_ph;
    logic [15:0] trim_p9;
    bit          sink_stall_long;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Bound the run: 412 items in all, with long stalls on both sides.
    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [31:0] sh(logic [31:0] x, int n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sx(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Work out the compensated reading from the local trim copy.
    function automatic t_reading compensate(logic [19:0] raw_t, logic [19:0] raw_p);
        t_reading    r;
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] a, b, d, fine, sq, p, at, ap;
        at = {12'd0, raw_t};
        ap = {12'd0, raw_p};
        t1 = {16'd0, trim_t[15:0]};
        t2 = sx(trim_t[31:16]);
        t3 = sx(trim_t[47:32]);
        p1 = {16'd0, trim_pl[15:0]};
        p2 = sx(trim_pl[31:16]);
        p3 = sx(trim_pl[47:32]);
        p4 = sx(trim_pl[63:48]);
        p5 = sx(trim_ph[15:0]);
        p6 = sx(trim_ph[31:16]);
        p7 = sx(trim_ph[47:32]);
        p8 = sx(trim_ph[63:48]);
        p9 = sx(trim_p9);
        a = sh(((at >> 3) - (t1 << 1)) * t2, 11);
        d = (at >> 4) - t1;
        b = sh(sh(d * d, 12) * t3, 14);
        fine = a + b;
        r.temp = sh(fine * 32'd5 + 32'd128, 8);
        a = sh(fine, 1) - 32'd64000;
        sq = sh(a, 2) * sh(a, 2);
        b = sh(sq, 11) * p6;
        b = b + ((a * p5) << 1);
        b = sh(b, 2) + (p4 << 16);
        a = sh(sh(p3 * sh(sq, 13), 3) + sh(p2 * a, 1), 18);
        a = sh((32'd32768 + a) * p1, 15);
        r.inv = (a == 32'd0);
        if (r.inv) begin
            p = 32'd0;
        end else begin
            p = ((32'd1048576 - ap) - sh(b, 12)) * 32'd3125;
            if (p < 32'h8000_0000) p = (p << 1) / a;
            else p = (p / a) * 32'd2;
            a = sh(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
            b = sh((p >> 2) * p8, 13);
            p = p + sh(a + b + p7, 4);
        end
        r.press = p;
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    // Write one trim register through the APB port, then read it back.
    task automatic write_trim(ptc_pkg::t_reg_idx idx, logic [63:0] val);
        logic [63:0] want;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        @(negedge i_clk) penable <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            ptc_pkg::REG_TEMP_TRIM: begin
                trim_t = val[47:0]; want = {16'd0, val[47:0]};
            end
            ptc_pkg::REG_PRESS_LOW: begin
                trim_pl = val; want = val;
            end
            ptc_pkg::REG_PRESS_HIGH: begin
                trim_ph = val; want = val;
            end
            default: begin
                trim_p9 = val[15:0]; want = {48'd0, val[15:0]};
            end
        endcase
        // read back: psel held from the write serves as setup, then access
        @(negedge i_clk) penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want)
            board.report($sformatf("register %0d reads %h want %h", idx, prdata, want));
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Hold until nothing is expected, then let the pipeline drain fully.
    task automatic settle();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    // Send one reading pair; valid stays high until the transfer and is left
    // high so that the next pair can follow at once.
    task automatic send(logic [19:0] rt, logic [19:0] rp);
        i_valid <= 1'b1;
        i_raw_temperature <= rt;
        i_raw_pressure <= rp;
        do @(posedge i_clk); while (!o_ready);
        board.note(compensate(rt, rp));
        @(negedge i_clk);
    endtask

    task automatic send_gapped(logic [19:0] rt, logic [19:0] rp);
        int g;
        send(rt, rp);
        g = gap_len();
        if (g != 0) begin
            i_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    // A typical trim set keeps most readings in the plausible range.
    function automatic logic [15:0] jitter(logic [15:0] v, int span);
        return v + 16'($urandom_range(0, 2 * span) - span);
    endfunction

    task automatic load_typical();
        write_trim(ptc_pkg::REG_TEMP_TRIM, {16'd0, jitter(16'hFF0C, 20),
                                            jitter(16'd26435, 500), jitter(16'd27504, 800)});
        write_trim(ptc_pkg::REG_PRESS_LOW, {jitter(16'd2855, 200), jitter(16'd8192, 200),
                                            jitter(16'hD6D0, 300), jitter(16'd36477, 500)});
        write_trim(ptc_pkg::REG_PRESS_HIGH, {jitter(16'd15500, 200), jitter(16'hFFF9, 3),
                                             jitter(16'hD4C6, 300), jitter(16'd140, 30)});
        write_trim(ptc_pkg::REG_PRESS_LAST, {48'd0, jitter(16'd6000, 300)});
    endtask

    task automatic load_random();
        write_trim(ptc_pkg::REG_TEMP_TRIM, {$urandom, $urandom});
        write_trim(ptc_pkg::REG_PRESS_LOW, {$urandom, $urandom});
        write_trim(ptc_pkg::REG_PRESS_HIGH, {$urandom, $urandom});
        write_trim(ptc_pkg::REG_PRESS_LAST, {$urandom, $urandom});
    endtask

    // Result side: random stalls, sample at the rising edge.
    initial begin
        int s;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (sink_stall_long || $urandom_range(0, 2) == 0) begin
                s = gap_len();
                if (s != 0) begin
                    i_ready <= 1'b0;
                    repeat (s) @(negedge i_clk);
                end
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            if (o_valid && i_ready)
                board.check(o_temperature_centi, o_pressure_pa, o_pressure_invalid);
        end
    end

    initial begin
        logic [19:0] rt, rp;
        i_rst_n = 1'b0; i_valid = 1'b0;
        i_raw_temperature = '0; i_raw_pressure = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        trim_t = '0; trim_pl = '0; trim_ph = '0; trim_p9 = '0;
        sink_stall_long = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Reset trims: divisor is zero, so every pressure is flagged invalid.
        send(20'd0, 20'd0);
        send(20'hFFFFF, 20'hFFFFF);
        settle();

        // Typical trims with the raw field extremes.
        load_typical();
        send(20'd519888, 20'd415148);
        send(20'd0, 20'hFFFFF);
        send(20'hFFFFF, 20'd0);
        send(20'h55555, 20'hAAAAA);
        send(20'hAAAAA, 20'h55555);
        send(20'd0, 20'd0);
        settle();

        // Extreme trims: all ones, then sign bits.
        write_trim(ptc_pkg::REG_TEMP_TRIM, 64'hFFFF_FFFF_FFFF_FFFF);
        write_trim(ptc_pkg::REG_PRESS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_trim(ptc_pkg::REG_PRESS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_trim(ptc_pkg::REG_PRESS_LAST, 64'hFFFF_FFFF_FFFF_7FFF);
        send(20'hFFFFF, 20'hFFFFF);
        send(20'd0, 20'd0);
        settle();
        write_trim(ptc_pkg::REG_TEMP_TRIM, 64'h8000_8000_0000);
        write_trim(ptc_pkg::REG_PRESS_LOW, 64'h8000_8000_8000_FFFF);
        write_trim(ptc_pkg::REG_PRESS_HIGH, 64'h8000_8000_8000_8000);
        write_trim(ptc_pkg::REG_PRESS_LAST, 64'h8000);
        send(20'h80000, 20'h80000);
        send(20'd1, 20'd1);
        settle();

        // Random part: mostly typical trims, some fully random ones.
        for (int phase = 0; phase < 8; phase++) begin
            if (phase % 3 == 2) load_random();
            else load_typical();
            sink_stall_long = (phase == 5);
            for (int n = 0; n < 50; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    rt = 20'($urandom); rp = 20'($urandom);
                end else begin
                    rt = 20'($urandom_range(400000, 600000));
                    rp = 20'($urandom_range(250000, 450000));
                end
                if (phase == 3 && n == 25) settle();  // drain with the sender held
                if (phase % 2 == 0) send_gapped(rt, rp);
                else send(rt, rp);
            end
            settle();
        end

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
